// ----- sv/wavhp_pkg.sv -----
// Shared types and constants for the WAVE header parser.
// Holds the parse phases, chunk kinds, status codes and the RIFF tag words.
package wavhp_pkg;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_SKIP,
    PH_HEAD,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    K_PLAIN,
    K_CUE,
    K_LIST
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_RIFF  = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_NOT_WAVE  = 3'd3,
    ST_NO_FMT    = 3'd4,
    ST_NOT_PCM   = 3'd5,
    ST_BAD_WIDTH = 3'd6,
    ST_BAD_LOOP  = 3'd7
  } status_t;

  // Tags as they sit in the little-endian field shift register.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_CUE  = 32'h2065_7563;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_LIST = 32'h5453_494c;
  localparam logic [31:0] TAG_LTXT = 32'h7478_746c;
  localparam logic [31:0] TAG_MARK = 32'h6b72_616d;

  localparam int unsigned MIN_FILE  = 36;
  localparam int unsigned CUE_ENTRY = 24;
  localparam int unsigned DIV_STEPS = 32;

endpackage

// ----- sv/wavhp_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Divides the data chunk size by the sample width; uses wavhp_pkg.
module wavhp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [12:0] divisor,
  output logic        busy,
  output logic [30:0] quotient
);
  import wavhp_pkg::*;

  logic [31:0] q;
  logic [12:0] rem;
  logic [12:0] dvs;
  logic [4:0]  count;
  logic [13:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem, q[31]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy  <= 1'b0;
      q     <= '0;
      rem   <= '0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      q     <= dividend;
      rem   <= '0;
      count <= '0;
    end else if (busy) begin
      // The dividend shifts out the top of q while quotient bits shift in below.
      q     <= {q[30:0], fits};
      rem   <= fits ? 13'(trial - {1'b0, dvs}) : trial[12:0];
      count <= 5'(count + 5'd1);
      if (count == 5'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
    end
  end

  assign quotient = q[30:0];

endmodule

// ----- sv/wav_header_parser_top.sv -----
// RIFF/WAVE PCM header parser, fed one file byte per item.
// Takes one byte per cycle while in_stall is low. At the size field of the first data chunk
// the divider runs and the input stalls meanwhile.
// After the last byte the input stalls while the result is formed; the finish flag is
// registered, and the result item is registered once the divider is idle and the slot is free.
// Synchronous active-high reset clears all parse state and the result valid flag.
module wav_header_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] channels,
  output logic [31:0] sample_rate,
  output logic [12:0] bytes_per_sample,
  output logic [30:0] sample_count,
  output logic [31:0] data_offset,
  output logic signed [31:0] loop_offset
);
  import wavhp_pkg::*;

  phase_t             phase, phase_next;
  kind_t              kind, kind_next;
  status_t            first_error, first_error_next;
  logic [31:0]        byte_index, byte_index_next;
  logic signed [32:0] riff_rem, riff_rem_next;
  logic [31:0]        decl_size, decl_size_next;
  logic [31:0]        chunk_rem, chunk_rem_next;
  logic [31:0]        field_shift, field_shift_next;
  logic [31:0]        tag_shift, tag_shift_next;
  logic               multi_cue, multi_cue_next;
  logic               ltxt_seen, ltxt_seen_next;
  logic [15:0]        held_channels, held_channels_next;
  logic [31:0]        held_rate, held_rate_next;
  logic [12:0]        held_width, held_width_next;
  logic [31:0]        held_data_offset, held_data_offset_next;
  logic [31:0]        held_loop_start, held_loop_start_next;
  logic [31:0]        held_loop_end, held_loop_end_next;
  logic [31:0]        fmt_size, fmt_size_next;
  logic [31:0]        chunk_len, chunk_len_next;
  logic [5:0]         chunk_pos, chunk_pos_next;
  logic [31:0]        list_value, list_value_next;
  logic               finish, finish_next;

  logic               accept;
  logic               emit;
  logic               clear_state;
  logic               div_start;
  logic               div_busy;
  logic [30:0]        div_quotient;

  logic [31:0]        fs;
  logic signed [32:0] fs_s;
  logic signed [32:0] rr;
  logic [31:0]        cr;
  logic [31:0]        fe;
  logic [5:0]         pos_inc;
  logic [35:0]        cue_need;
  logic [35:0]        cue_room;
  logic [15:0]        bits;

  status_t            fin_status;
  logic signed [32:0] smp, ls, lo;

  logic [2:0]         status_next;

  assign in_stall = finish || div_busy;
  assign accept   = in_valid && !in_stall;
  assign emit     = finish && !div_busy && (!out_valid || !out_stall);

  wavhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear_state),
    .start    (div_start),
    .dividend (fs),
    .divisor  (held_width),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Final status and loop check from the held fields.
  always_comb begin
    smp = $signed({2'b00, div_quotient});
    ls  = $signed({held_loop_end[31], held_loop_end});
    lo  = $signed({held_loop_start[31], held_loop_start});
    if (byte_index < 32'(MIN_FILE) || first_error == ST_NOT_RIFF) begin
      fin_status = ST_NOT_RIFF;
    end else if (first_error == ST_TRUNC ||
                 {1'b0, decl_size} > 33'({1'b0, byte_index} - 33'd8)) begin
      fin_status = ST_TRUNC;
    end else begin
      fin_status = first_error;
    end
    if (fin_status == ST_OK && (ls > smp || lo > smp)) begin
      fin_status = ST_BAD_LOOP;
    end
    status_next = fin_status;
  end

  always_comb begin
    phase_next            = phase;
    kind_next             = kind;
    first_error_next      = first_error;
    byte_index_next       = byte_index;
    riff_rem_next         = riff_rem;
    decl_size_next        = decl_size;
    chunk_rem_next        = chunk_rem;
    field_shift_next      = field_shift;
    tag_shift_next        = tag_shift;
    multi_cue_next        = multi_cue;
    ltxt_seen_next        = ltxt_seen;
    held_channels_next    = held_channels;
    held_rate_next        = held_rate;
    held_width_next       = held_width;
    held_data_offset_next = held_data_offset;
    held_loop_start_next  = held_loop_start;
    held_loop_end_next    = held_loop_end;
    fmt_size_next         = fmt_size;
    chunk_len_next        = chunk_len;
    chunk_pos_next        = chunk_pos;
    list_value_next       = list_value;
    finish_next           = finish;
    div_start             = 1'b0;
    clear_state           = 1'b0;

    fs       = {data_byte, field_shift[31:8]};
    fs_s     = $signed({fs[31], fs});
    rr       = 33'(riff_rem - 33'sd1);
    cr       = 32'(chunk_rem - 32'd1);
    fe       = ($signed(fmt_size) < 32'sd16) ? 32'd16 : fmt_size;
    pos_inc  = (chunk_pos == 6'h3f) ? chunk_pos : 6'(chunk_pos + 6'd1);
    cue_need = 36'({4'b0, fs} << 4) + 36'({4'b0, fs} << 3);
    cue_room = 36'({4'b0, chunk_len} - 36'd4);
    bits     = fs[31:16];

    if (accept) begin
      field_shift_next = fs;
      case (phase)
        PH_HDR: begin
          if (byte_index == 32'd3 && fs != TAG_RIFF && first_error == ST_OK) begin
            first_error_next = ST_NOT_RIFF;
          end
          if (byte_index == 32'd7) begin
            decl_size_next = fs;
            if ($signed(fs) < 32'sd36 && first_error == ST_OK) begin
              first_error_next = ST_TRUNC;
            end
          end
          if (byte_index == 32'd11 && fs != TAG_WAVE && first_error == ST_OK) begin
            first_error_next = ST_NOT_WAVE;
          end
          if (byte_index == 32'd15 && fs != TAG_FMT && first_error == ST_OK) begin
            first_error_next = ST_NO_FMT;
          end
          if (byte_index == 32'd19) begin
            fmt_size_next = fs;
          end
          if (byte_index == 32'd21 && bits != 16'd1 && first_error == ST_OK) begin
            first_error_next = ST_NOT_PCM;
          end
          if (byte_index == 32'd23) begin
            held_channels_next = bits;
          end
          if (byte_index == 32'd27) begin
            held_rate_next = fs;
          end
          if (byte_index == 32'd35) begin
            if (bits[2:0] != 3'd0 && first_error == ST_OK) begin
              first_error_next = ST_BAD_WIDTH;
            end
            held_width_next      = bits[15:3];
            held_loop_start_next = '1;
            if (first_error_next != ST_OK) begin
              phase_next = PH_DONE;
            end else begin
              riff_rem_next  = 33'($signed({decl_size[31], decl_size}) - 33'sd12
                                   - $signed({1'b0, fe}));
              chunk_rem_next = 32'(fe - 32'd16);
              if (fe == 32'd16) begin
                if (riff_rem_next < 33'sd8) begin
                  phase_next = PH_DONE;
                end else begin
                  phase_next     = PH_HEAD;
                  chunk_pos_next = '0;
                end
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          chunk_rem_next = cr;
          if (cr == 32'd0) begin
            if (riff_rem < 33'sd8) begin
              phase_next = PH_DONE;
            end else begin
              phase_next     = PH_HEAD;
              chunk_pos_next = '0;
            end
          end
        end
        PH_HEAD: begin
          riff_rem_next = rr;
          if (chunk_pos == 6'd3) begin
            tag_shift_next = fs;
          end
          if (chunk_pos != 6'd7) begin
            chunk_pos_next = pos_inc;
          end else if (fs_s <= 33'sd0 || fs_s > rr) begin
            phase_next = PH_DONE;
          end else begin
            chunk_len_next = fs;
            chunk_rem_next = {31'(32'(fs + 32'd1) >> 1), 1'b0};
            chunk_pos_next = '0;
            kind_next      = K_PLAIN;
            phase_next     = PH_BODY;
            if (fs >= 32'd4) begin
              if (tag_shift == TAG_CUE) begin
                kind_next = K_CUE;
              end else if (tag_shift == TAG_DATA && held_data_offset == 32'd0) begin
                if (held_width == 13'd0) begin
                  if (first_error == ST_OK) begin
                    first_error_next = ST_BAD_WIDTH;
                  end
                  phase_next = PH_DONE;
                end else begin
                  div_start             = 1'b1;
                  held_data_offset_next = 32'(byte_index + 32'd1);
                end
              end else if (tag_shift == TAG_LIST && !held_loop_start[31] &&
                           held_loop_end == 32'd0) begin
                kind_next = K_LIST;
              end
            end
          end
        end
        PH_BODY: begin
          riff_rem_next = rr;
          case (kind)
            K_CUE: begin
              if (chunk_pos == 6'd3) begin
                multi_cue_next = (fs > 32'd1);
                if (!(fs_s >= 33'sd1 && cue_room >= cue_need)) begin
                  kind_next = K_PLAIN;
                end
              end else if (chunk_pos == 6'd27) begin
                held_loop_start_next = fs;
              end else if (chunk_pos == 6'd51 && multi_cue) begin
                held_loop_end_next = 32'(held_loop_start + fs);
              end
            end
            K_LIST: begin
              if (chunk_len >= 32'(CUE_ENTRY)) begin
                if (chunk_pos == 6'd7) begin
                  ltxt_seen_next = (fs == TAG_LTXT);
                end
                if (chunk_pos == 6'd19) begin
                  list_value_next = fs;
                end
                if (chunk_pos == 6'd23 && ltxt_seen && fs == TAG_MARK) begin
                  held_loop_end_next = 32'(held_loop_start + list_value);
                end
              end
            end
            default: begin
            end
          endcase
          chunk_pos_next = pos_inc;
          chunk_rem_next = cr;
          if (cr == 32'd0) begin
            if (rr < 33'sd8) begin
              phase_next = PH_DONE;
            end else begin
              phase_next     = PH_HEAD;
              chunk_pos_next = '0;
            end
          end
        end
        default: begin
        end
      endcase
      if (byte_index != 32'hffff_ffff) begin
        byte_index_next = 32'(byte_index + 32'd1);
      end
      if (last_byte) begin
        finish_next = 1'b1;
      end
    end

    // The result is formed and the parser rearms for the next file.
    if (emit) begin
      clear_state           = 1'b1;
      finish_next           = 1'b0;
      phase_next            = PH_HDR;
      kind_next             = K_PLAIN;
      first_error_next      = ST_OK;
      byte_index_next       = '0;
      riff_rem_next         = '0;
      decl_size_next        = '0;
      chunk_rem_next        = '0;
      field_shift_next      = '0;
      tag_shift_next        = '0;
      multi_cue_next        = 1'b0;
      ltxt_seen_next        = 1'b0;
      held_channels_next    = '0;
      held_rate_next        = '0;
      held_width_next       = '0;
      held_data_offset_next = '0;
      held_loop_start_next  = '1;
      held_loop_end_next    = '0;
      fmt_size_next         = '0;
      chunk_len_next        = '0;
      chunk_pos_next        = '0;
      list_value_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR;
      kind             <= K_PLAIN;
      first_error      <= ST_OK;
      byte_index       <= '0;
      riff_rem         <= '0;
      decl_size        <= '0;
      chunk_rem        <= '0;
      field_shift      <= '0;
      tag_shift        <= '0;
      multi_cue        <= 1'b0;
      ltxt_seen        <= 1'b0;
      held_channels    <= '0;
      held_rate        <= '0;
      held_width       <= '0;
      held_data_offset <= '0;
      held_loop_start  <= '1;
      held_loop_end    <= '0;
      fmt_size         <= '0;
      chunk_len        <= '0;
      chunk_pos        <= '0;
      list_value       <= '0;
      finish           <= 1'b0;
    end else begin
      phase            <= phase_next;
      kind             <= kind_next;
      first_error      <= first_error_next;
      byte_index       <= byte_index_next;
      riff_rem         <= riff_rem_next;
      decl_size        <= decl_size_next;
      chunk_rem        <= chunk_rem_next;
      field_shift      <= field_shift_next;
      tag_shift        <= tag_shift_next;
      multi_cue        <= multi_cue_next;
      ltxt_seen        <= ltxt_seen_next;
      held_channels    <= held_channels_next;
      held_rate        <= held_rate_next;
      held_width       <= held_width_next;
      held_data_offset <= held_data_offset_next;
      held_loop_start  <= held_loop_start_next;
      held_loop_end    <= held_loop_end_next;
      fmt_size         <= fmt_size_next;
      chunk_len        <= chunk_len_next;
      chunk_pos        <= chunk_pos_next;
      list_value       <= list_value_next;
      finish           <= finish_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // On any error every field other than status reads zero.
  always_ff @(posedge clk) begin
    if (emit) begin
      status <= status_next;
      if (fin_status == ST_OK) begin
        channels         <= held_channels;
        sample_rate      <= held_rate;
        bytes_per_sample <= held_width;
        sample_count     <= (ls > 33'sd0) ? held_loop_end[30:0] : div_quotient;
        data_offset      <= held_data_offset;
        loop_offset      <= $signed(held_loop_start);
      end else begin
        channels         <= '0;
        sample_rate      <= '0;
        bytes_per_sample <= '0;
        sample_count     <= '0;
        data_offset      <= '0;
        loop_offset      <= '0;
      end
    end
  end

endmodule

// ----- verif/tb_wav_header_parser_top.sv -----
// Self-checking testbench for wav_header_parser_top, built on wavhp_pkg.
// Whole files are streamed in one byte per item, and each result is compared field by
// field with a header predictor that the bench keeps for itself.
module tb_wav_header_parser_top;
  import wavhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    status_t     st;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [12:0] width;
    logic [30:0] count;
    logic [31:0] offset;
    logic [31:0] loop_start;
  } wave_info_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [2:0]  status;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic [12:0] bytes_per_sample;
  logic [30:0] sample_count;
  logic [31:0] data_offset;
  logic signed [31:0] loop_offset;

  wave_info_t  header_expect_q[$];
  logic [7:0]  file_q[$];
  int unsigned mismatches = 0;
  int unsigned files_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned headers_checked = 0;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;

  // Predictor state.
  phase_t      p_phase;
  kind_t       p_kind;
  logic [31:0] p_index, p_decl, p_fshift, p_tshift, p_cues, p_rate, p_width;
  logic [31:0] p_samples, p_doff, p_lstart, p_lend, p_fmt, p_clen, p_cpos, p_listv;
  logic [15:0] p_chans;
  logic [2:0]  p_err;
  longint      p_riff_left;
  longint unsigned p_chunk_left;

  wav_header_parser_top dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic void pred_reset();
    p_phase = PH_HDR; p_kind = K_PLAIN;
    p_index = 0; p_decl = 0; p_fshift = 0; p_tshift = 0; p_cues = 0;
    p_rate = 0; p_width = 0; p_samples = 0; p_doff = 0; p_lstart = '1;
    p_lend = 0; p_fmt = 0; p_clen = 0; p_cpos = 0; p_listv = 0;
    p_chans = 0; p_err = 0; p_riff_left = 0; p_chunk_left = 0;
  endfunction

  function automatic void pred_fail(status_t code);
    if (p_err == 0) p_err = code;
  endfunction

  function automatic void pred_next_chunk();
    if (p_riff_left < 8) p_phase = PH_DONE;
    else begin
      p_phase = PH_HEAD;
      p_cpos = 0;
    end
  endfunction

  function automatic void pred_header(logic [31:0] idx, logic [31:0] fs);
    longint fe;
    if (idx == 3 && fs != TAG_RIFF) pred_fail(ST_NOT_RIFF);
    if (idx == 7) begin
      p_decl = fs;
      if (sx(fs) < 36) pred_fail(ST_TRUNC);
    end
    if (idx == 11 && fs != TAG_WAVE) pred_fail(ST_NOT_WAVE);
    if (idx == 15 && fs != TAG_FMT) pred_fail(ST_NO_FMT);
    if (idx == 19) p_fmt = fs;
    if (idx == 21 && fs[31:16] != 16'd1) pred_fail(ST_NOT_PCM);
    if (idx == 23) p_chans = fs[31:16];
    if (idx == 27) p_rate = fs;
    if (idx == 35) begin
      if (fs[18:16] != 3'd0) pred_fail(ST_BAD_WIDTH);
      p_width = {19'd0, fs[31:19]};
      p_lstart = '1;
      if (p_err != 0) begin
        p_phase = PH_DONE;
        return;
      end
      // A format size below 16 counts as 16.
      fe = (sx(p_fmt) < 16) ? 16 : longint'(p_fmt);
      p_riff_left = sx(p_decl) - 12 - fe;
      p_chunk_left = fe - 16;
      if (p_chunk_left == 0) pred_next_chunk();
      else p_phase = PH_SKIP;
    end
  endfunction

  function automatic void pred_chunk_head(logic [31:0] idx, logic [31:0] fs);
    p_riff_left--;
    if (p_cpos == 3) p_tshift = fs;
    if (p_cpos != 7) begin
      p_cpos++;
      return;
    end
    if (sx(fs) <= 0 || sx(fs) > p_riff_left) begin
      p_phase = PH_DONE;
      return;
    end
    p_clen = fs;
    p_chunk_left = (longint'(fs) + 1) & ~64'd1;
    p_cpos = 0;
    p_kind = K_PLAIN;
    if (fs >= 4) begin
      if (p_tshift == TAG_CUE) p_kind = K_CUE;
      else if (p_tshift == TAG_DATA && p_doff == 0) begin
        if (p_width == 0) begin
          pred_fail(ST_BAD_WIDTH);
          p_phase = PH_DONE;
          return;
        end
        p_samples = fs / p_width;
        p_doff = idx + 1;
      end else if (p_tshift == TAG_LIST && sx(p_lstart) >= 0 && p_lend == 0)
        p_kind = K_LIST;
    end
    p_phase = PH_BODY;
  endfunction

  function automatic void pred_chunk_body(logic [31:0] fs);
    p_riff_left--;
    if (p_kind == K_CUE) begin
      if (p_cpos == 3) begin
        p_cues = fs;
        if (!(sx(fs) >= 1 && longint'(p_clen) - 4 >= longint'(fs) * CUE_ENTRY))
          p_kind = K_PLAIN;
      end else if (p_cpos == 27) p_lstart = fs;
      else if (p_cpos == 51 && p_cues > 1) p_lend = p_lstart + fs;
    end else if (p_kind == K_LIST && p_clen >= 24) begin
      if (p_cpos == 7) p_tshift = (fs == TAG_LTXT) ? 32'd1 : 32'd0;
      if (p_cpos == 19) p_listv = fs;
      if (p_cpos == 23 && p_tshift == 1 && fs == TAG_MARK) p_lend = p_lstart + p_listv;
    end
    p_cpos++;
    p_chunk_left--;
    if (p_chunk_left == 0) pred_next_chunk();
  endfunction

  function automatic void predict_header(logic [7:0] b, logic last);
    wave_info_t info;
    logic [31:0] idx;
    longint smp, le, ls;
    idx = p_index;
    p_fshift = {b, p_fshift[31:8]};
    case (p_phase)
      PH_HDR: pred_header(idx, p_fshift);
      PH_SKIP: begin
        p_chunk_left--;
        if (p_chunk_left == 0) pred_next_chunk();
      end
      PH_HEAD: pred_chunk_head(idx, p_fshift);
      PH_BODY: pred_chunk_body(p_fshift);
      default: ;
    endcase
    if (p_index != 32'hFFFF_FFFF) p_index++;
    if (!last) return;
    info = '0;
    if (p_index < MIN_FILE || p_err == ST_NOT_RIFF) info.st = ST_NOT_RIFF;
    else if (p_err == ST_TRUNC || longint'(p_decl) > longint'(p_index) - 8) info.st = ST_TRUNC;
    else info.st = status_t'(p_err);
    smp = longint'(p_samples);
    le = sx(p_lend);
    ls = sx(p_lstart);
    if (info.st == ST_OK && (le > smp || ls > smp)) info.st = ST_BAD_LOOP;
    if (info.st == ST_OK) begin
      info.chans = p_chans;
      info.rate = p_rate;
      info.width = p_width[12:0];
      info.count = (le > 0) ? le[30:0] : smp[30:0];
      info.offset = p_doff;
      info.loop_start = p_lstart;
    end
    header_expect_q.push_back(info);
    pred_reset();
  endfunction

  // Result side: random stall before each result, then watch for acceptance.
  initial begin
    int unsigned hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    wave_info_t want;
    if (!rst && out_valid && !out_stall) begin
      if (header_expect_q.size() == 0) begin
        $error("result with no expected header pending");
        mismatches++;
      end else begin
        want = header_expect_q.pop_front();
        headers_checked++;
        if (status != want.st) begin
          $error("status expected %0d got %0d", want.st, status); mismatches++;
        end
        if (channels != want.chans) begin
          $error("channels expected %0d got %0d", want.chans, channels); mismatches++;
        end
        if (sample_rate != want.rate) begin
          $error("sample_rate expected %0d got %0d", want.rate, sample_rate); mismatches++;
        end
        if (bytes_per_sample != want.width) begin
          $error("bytes_per_sample expected %0d got %0d", want.width, bytes_per_sample);
          mismatches++;
        end
        if (sample_count != want.count) begin
          $error("sample_count expected %0d got %0d", want.count, sample_count); mismatches++;
        end
        if (data_offset != want.offset) begin
          $error("data_offset expected %0d got %0d", want.offset, data_offset); mismatches++;
        end
        if (loop_offset != want.loop_start) begin
          $error("loop_offset expected %0d got %0d", $signed(want.loop_start), loop_offset);
          mismatches++;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    predict_header(b, last);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
    files_sent++;
  endtask

  task automatic put16(logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic put_noise(int unsigned n);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  task automatic put_header(logic [31:0] fmt_len, logic [15:0] code, logic [15:0] nch,
                            logic [31:0] rate, logic [15:0] bits);
    put32(TAG_RIFF); put32(32'd0); put32(TAG_WAVE); put32(TAG_FMT);
    put32(fmt_len); put16(code); put16(nch); put32(rate);
    put32(rate * nch * (bits >> 3)); put16(nch * (bits >> 3)); put16(bits);
    if (fmt_len > 16 && fmt_len < 64) put_noise(fmt_len - 16);
  endtask

  task automatic put_chunk(logic [31:0] tag, int unsigned len);
    put32(tag); put32(len); put_noise(len + (len & 1));
  endtask

  task automatic put_cue(logic [31:0] npoints, int unsigned entries,
                         logic [31:0] first_pos, logic [31:0] second_pos);
    put32(TAG_CUE); put32(4 + entries * CUE_ENTRY); put32(npoints);
    for (int i = 0; i < entries; i++) begin
      put_noise(20);
      put32(i == 0 ? first_pos : second_pos);
    end
  endtask

  task automatic put_list(logic [31:0] span, bit good);
    put32(TAG_LIST); put32(24); put32(32'h6c74_6461);
    put32(good ? TAG_LTXT : 32'($urandom));
    put_noise(8);
    put32(span);
    put32(good ? TAG_MARK : 32'($urandom));
  endtask

  // Patch the RIFF size so it matches the file, then add a signed skew.
  task automatic fix_size(int skew);
    logic [31:0] sz;
    if (file_q.size() < 8) return;
    sz = file_q.size() - 8 + skew;
    for (int i = 0; i < 4; i++) file_q[4 + i] = sz[8*i +: 8];
  endtask

  task automatic test_good_files();
    put_header(16, 1, 2, 44100, 16); put_chunk(TAG_DATA, 20); fix_size(0); send_file();
    put_header(16, 1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFF8); put_chunk(TAG_DATA, 16);
    fix_size(0); send_file();
    // Header and nothing else: its RIFF size falls below 36, so it is reported as truncated.
    put_header(16, 1, 1, 8000, 8); fix_size(0); send_file();
    put_header(18, 1, 1, 8000, 8); put_chunk(TAG_DATA, 5); fix_size(0); send_file();
    put_header(8, 1, 1, 8000, 8); put_chunk(TAG_DATA, 6); fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 8); put_chunk(32'h6b6e_756a, 2); put_chunk(TAG_DATA, 9);
    put_chunk(TAG_DATA, 3); fix_size(0); put_noise(5); send_file();
  endtask

  task automatic test_header_errors();
    put_noise(20); send_file();
    put_noise(1); send_file();
    put_header(16, 1, 1, 8000, 8); file_q[0] = 8'h00; fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 8); file_q[8] = 8'h00; fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 8); file_q[12] = 8'h00; fix_size(0); send_file();
    put_header(16, 3, 1, 8000, 8); fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 12); fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 0); put_chunk(TAG_DATA, 8); fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 8); put_chunk(TAG_DATA, 8); fix_size(4); send_file();
    put_header(16, 1, 1, 8000, 8); fix_size(-20); send_file();
    put_header(16, 1, 1, 8000, 8); put32(TAG_DATA); put32(0); put_noise(6);
    fix_size(0); send_file();
    file_q.delete();
  endtask

  task automatic test_loop_marks();
    put_header(16, 1, 1, 8000, 8); put_cue(2, 2, 3, 10); put_chunk(TAG_DATA, 20);
    fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 8); put_cue(1, 1, 4, 0); put_list(12, 1);
    put_chunk(TAG_DATA, 20); fix_size(0); send_file();
    put_header(16, 1, 1, 8000, 8); put_cue(1, 1, 15, 0); put_list(12, 1);
    put_chunk(TAG_DATA, 20); fix_size(0); send_file();
    put_header(16, 1, 2, 8000, 16); put_cue(32'hFFFF_FFFF, 1, 2, 0);
    put_chunk(TAG_DATA, 20); fix_size(0); send_file();
  endtask

  task automatic random_file();
    int unsigned pick, nchunks;
    logic [15:0] bits;
    logic [31:0] fmt_len;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      put_noise($urandom_range(1, 60));
      send_file();
      return;
    end
    case ($urandom_range(0, 9))
      0: bits = 16'($urandom);
      1: bits = 16'($urandom_range(0, 4)) << 3;
      default: bits = 16'($urandom_range(1, 4)) << 3;
    endcase
    case ($urandom_range(0, 9))
      0: fmt_len = $urandom_range(0, 15);
      1: fmt_len = 16 + 2 * $urandom_range(1, 6);
      2: fmt_len = $urandom;
      default: fmt_len = 16;
    endcase
    put_header(fmt_len, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1,
               16'($urandom), $urandom, bits);
    if (pick < 15) file_q[$urandom_range(0, 35)] = 8'($urandom);
    nchunks = $urandom_range(0, 4);
    repeat (nchunks) begin
      case ($urandom_range(0, 5))
        0: put_cue(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 2),
                   $urandom_range(1, 2), $urandom_range(0, 30), $urandom_range(0, 30));
        1: put_list($urandom_range(0, 30), $urandom_range(0, 3) != 0);
        2, 3: put_chunk(TAG_DATA, $urandom_range(0, 40));
        default: put_chunk($urandom, $urandom_range(0, 10));
      endcase
    end
    case ($urandom_range(0, 9))
      0: fix_size($urandom_range(0, 8) - 4);
      1: fix_size($urandom_range(0, 4));
      default: fix_size(0);
    endcase
    case ($urandom_range(0, 9))
      0: put_noise($urandom_range(1, 8));
      1: repeat ($urandom_range(1, 8)) if (file_q.size() > 1) void'(file_q.pop_back());
      default: ;
    endcase
    send_file();
  endtask

  task automatic test_random_files();
    for (int i = 0; i < 4; i++) begin
      // Run some files with both sides always ready.
      no_idle = (i % 2) == 1;
      random_file();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    pred_reset();
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_good_files();
    test_header_errors();
    test_loop_marks();
    test_random_files();
    @(negedge clk) in_valid <= 1'b0;
    while (header_expect_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d files in %0d bytes, %0d header results compared.",
             files_sent, bytes_sent, headers_checked);
    $display("Covered good files, every status code, cue and LIST loops, odd fmt sizes.");
    if (mismatches == 0 && header_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/wavhp_pkg.sv
sv/wavhp_div.sv
sv/wav_header_parser_top.sv
verif/tb_wav_header_parser_top.sv
